// ===== src/fpci_pkg.sv =====
// ----------------------------------------------------------------------------
// fpci_pkg
// Shared widths and handshake structs for the factorial prime-count
// inverse unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fpci_pkg;

  // Field widths of the query and of the result.
  localparam int TARGET_W = 20;
  localparam int BASE_W   = 17;
  // The running sum stops as soon as it passes the target. One step adds at
  // most a few tens, so one bit above the target width is enough.
  localparam int SUM_W    = TARGET_W + 1;

  // Query handed from the channel logic to the engine.
  typedef struct packed {
    logic                start;
    logic [TARGET_W-1:0] target;
  } req_t;

  // Engine status and answer.
  typedef struct packed {
    logic              ready;
    logic              done;
    logic              found;
    logic [BASE_W-1:0] base;
  } resp_t;

endpackage : fpci_pkg

`default_nettype wire

// ===== src/factorial_prime_count_inverse_unit.sv =====
// ----------------------------------------------------------------------------
// factorial_prime_count_inverse_unit
// Finds the x whose factorial has a given number of prime factors, counted
// with multiplicity, by walking a table of per-integer factor counts.
// ----------------------------------------------------------------------------
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   query    | in_valid, in_ready, in_target_count[19:0] | into block
//   answer   | out_valid, out_ready, out_found,          | out of block
//            | out_factorial_base[16:0]                  |
//
// After reset the unit clears its count table and then sieves it, with
// in_ready low throughout. Each query then walks the table from entry 2 up
// to the x where the walk stops, at most SEARCH_LIMIT, reading one entry and
// then adding it to the running sum before stepping on; the answer is
// registered once the walk stops. The single RAM port, which the walk reads
// one entry at a time, sets this pace. Targets of zero or above COUNT_LIMIT
// skip the walk. The answer sits in an output register, so one new query can
// be taken while the previous answer still waits for out_ready.
//
`default_nettype none

module factorial_prime_count_inverse_unit #(
  parameter int SEARCH_LIMIT = 65536,
  parameter int COUNT_LIMIT  = 1048575
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [fpci_pkg::TARGET_W-1:0] in_target_count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_found,
  output logic [fpci_pkg::BASE_W-1:0]        out_factorial_base
);

  import fpci_pkg::*;

  req_t              req;
  resp_t             resp;
  logic              out_valid_r, out_valid_nxt;
  logic              found_r;
  logic [BASE_W-1:0] base_r;
  logic              hold;

  // The engine may only finish a transaction when the answer register is
  // free or is being emptied in this same cycle.
  assign hold       = out_valid_r && !out_ready;

  assign in_ready   = resp.ready;
  assign req.start  = in_valid && resp.ready;
  assign req.target = in_target_count;

  fpci_engine #(
    .SEARCH_LIMIT (SEARCH_LIMIT),
    .COUNT_LIMIT  (COUNT_LIMIT)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .hold  (hold),
    .resp  (resp)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (resp.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (resp.done) begin
      found_r <= resp.found;
      base_r  <= resp.base;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = found_r;
  assign out_factorial_base = base_r;

`ifndef NO_ASSERTIONS
  // An accepted query makes the unit busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("top: still ready right after accepting a query");

  // A new answer never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    resp.done |-> (!out_valid_r || out_ready))
    else $error("top: answer register overwritten");

  // A not-found answer always carries a zero base.
  a_zero_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_factorial_base == '0))
    else $error("top: not-found answer with nonzero base");
`endif

endmodule : factorial_prime_count_inverse_unit

`default_nettype wire

// ===== src/fpci_ram.sv =====
// ----------------------------------------------------------------------------
// fpci_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fpci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule : fpci_ram

`default_nettype wire

// ===== src/fpci_engine.sv =====
// ----------------------------------------------------------------------------
// fpci_engine
// Sequencer that builds a table of prime-factor counts in RAM once after
// reset and then answers each query by walking that table.
// ----------------------------------------------------------------------------
`default_nettype none

module fpci_engine #(
  parameter int SEARCH_LIMIT = 65536,
  parameter int COUNT_LIMIT  = 1048575
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire fpci_pkg::req_t  req,
  input  wire logic            hold,
  output fpci_pkg::resp_t      resp
);

  import fpci_pkg::*;

  localparam int DEPTH = SEARCH_LIMIT + 1;
  localparam int AW    = $clog2(DEPTH);
  // The count of any entry never exceeds log2 of the limit.
  localparam int OW    = $clog2(AW + 1);
  localparam int EW    = AW + BASE_W;
  localparam int PW    = 2 * AW;

  localparam logic [AW-1:0] LIM = AW'(SEARCH_LIMIT);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_P_RD  = 4'd2;
  localparam logic [3:0] S_P_CHK = 4'd3;
  localparam logic [3:0] S_M_RD  = 4'd4;
  localparam logic [3:0] S_M_WR  = 4'd5;
  localparam logic [3:0] S_Q_MUL = 4'd6;
  localparam logic [3:0] S_Q_CHK = 4'd7;
  localparam logic [3:0] S_W_RD  = 4'd8;
  localparam logic [3:0] S_W_ADD = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]          state_r, state_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [AW-1:0]       p_r, p_nxt;
  logic [AW-1:0]       q_r, q_nxt;
  logic [PW-1:0]       prod_r, prod_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [TARGET_W-1:0] target_r, target_nxt;
  logic                found_r, found_nxt;
  logic [AW-1:0]       base_r, base_nxt;

  // Shared index adder: steps the clear address, the prime candidate, the
  // multiple being marked and the walk index.
  logic [AW:0]         add_a, add_b, add_out;
  logic [SUM_W-1:0]    acc;
  logic [EW-1:0]       base_ext;

  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [OW-1:0]       ram_wdata, ram_rdata;

  fpci_ram #(
    .WIDTH (OW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    add_a   = ((state_r == S_P_CHK) || (state_r == S_Q_CHK)) ? {1'b0, p_r} : {1'b0, idx_r};
    add_b   = (state_r == S_M_WR) ? {1'b0, q_r} : (AW + 1)'(1);
    add_out = add_a + add_b;
    acc     = sum_r + SUM_W'(ram_rdata);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = (state_r == S_P_RD) ? p_r : idx_r;
    ram_wdata = '0;
    if (state_r == S_CLR) begin
      ram_we = 1'b1;
    end else if (state_r == S_M_WR) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata + OW'(1);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    p_nxt      = p_r;
    q_nxt      = q_r;
    prod_nxt   = prod_r;
    sum_nxt    = sum_r;
    target_nxt = target_r;
    found_nxt  = found_r;
    base_nxt   = base_r;
    case (state_r)
      S_CLR: begin
        if (idx_r == LIM) begin
          p_nxt     = AW'(2);
          state_nxt = S_P_RD;
        end else begin
          idx_nxt = add_out[AW-1:0];
        end
      end
      S_P_RD: begin
        state_nxt = S_P_CHK;
      end
      S_P_CHK: begin
        // All smaller primes have marked p already; an empty entry is prime.
        if (ram_rdata == '0) begin
          q_nxt     = p_r;
          idx_nxt   = p_r;
          state_nxt = S_M_RD;
        end else if (p_r == LIM) begin
          state_nxt = S_IDLE;
        end else begin
          p_nxt     = add_out[AW-1:0];
          state_nxt = S_P_RD;
        end
      end
      S_M_RD: begin
        state_nxt = S_M_WR;
      end
      S_M_WR: begin
        if (add_out > {1'b0, LIM}) begin
          state_nxt = S_Q_MUL;
        end else begin
          idx_nxt   = add_out[AW-1:0];
          state_nxt = S_M_RD;
        end
      end
      S_Q_MUL: begin
        prod_nxt  = {{AW{1'b0}}, q_r} * {{AW{1'b0}}, p_r};
        state_nxt = S_Q_CHK;
      end
      S_Q_CHK: begin
        // Each higher power of p adds one more factor to its multiples.
        if (prod_r <= {{AW{1'b0}}, LIM}) begin
          q_nxt     = prod_r[AW-1:0];
          idx_nxt   = prod_r[AW-1:0];
          state_nxt = S_M_RD;
        end else if (p_r == LIM) begin
          state_nxt = S_IDLE;
        end else begin
          p_nxt     = add_out[AW-1:0];
          state_nxt = S_P_RD;
        end
      end
      S_IDLE: begin
        if (req.start) begin
          target_nxt = req.target;
          sum_nxt    = '0;
          base_nxt   = '0;
          found_nxt  = 1'b0;
          if (req.target == '0) begin
            found_nxt = 1'b1;
            state_nxt = S_DONE;
          end else if (32'(req.target) > 32'(COUNT_LIMIT)) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = AW'(2);
            state_nxt = S_W_RD;
          end
        end
      end
      S_W_RD: begin
        state_nxt = S_W_ADD;
      end
      S_W_ADD: begin
        sum_nxt = acc;
        if (acc == {1'b0, target_r}) begin
          found_nxt = 1'b1;
          base_nxt  = idx_r;
          state_nxt = S_DONE;
        end else if ((acc > {1'b0, target_r}) || (idx_r == LIM)) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = add_out[AW-1:0];
          state_nxt = S_W_RD;
        end
      end
      S_DONE: begin
        if (!hold) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
    p_r      <= p_nxt;
    q_r      <= q_nxt;
    prod_r   <= prod_nxt;
    sum_r    <= sum_nxt;
    target_r <= target_nxt;
    found_r  <= found_nxt;
    base_r   <= base_nxt;
  end

  assign base_ext   = {{BASE_W{1'b0}}, base_r};
  assign resp.ready = (state_r == S_IDLE);
  assign resp.done  = (state_r == S_DONE) && !hold;
  assign resp.found = found_r;
  assign resp.base  = found_r ? base_ext[BASE_W-1:0] : '0;

`ifndef NO_ASSERTIONS
  // While walking, the running sum never has passed the target.
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_W_RD) |-> (sum_r < {1'b0, target_r}))
    else $error("fpci_engine: running sum passed the target during walk");

  // Table updates only touch entries inside the search range.
  a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_M_WR) |-> (idx_r <= LIM) && (idx_r >= q_r))
    else $error("fpci_engine: marking outside the table");

  // A found answer is either the empty factorial or a base of at least two.
  a_base_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (resp.done && found_r) |-> ((base_r == '0) || (base_r >= AW'(2))))
    else $error("fpci_engine: impossible base reported");

  // A finished result leaves the engine in the following cycle.
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    resp.done |=> (state_r == S_IDLE))
    else $error("fpci_engine: result delivered but engine not idle");
`endif

endmodule : fpci_engine

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for factorial_prime_count_inverse_unit. Queries go
// in over a valid/ready channel in random bursts while the answer side stalls
// on its own pattern. Every answer is checked against an in-bench prediction
// built from a table of prime-factor totals of x! for x up to the search
// limit.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpci_pkg::*;

  localparam int SEARCH_LIMIT = 65536;
  localparam int COUNT_LIMIT  = 1048575;

  // Generous bound on the whole run, which covers the count table build after
  // reset, the two full-range queries, and the random queries, which walk at
  // most a few thousand entries each.
  localparam int RUN_LIMIT      = 10_000_000;
  // One query can walk the whole table, so after the last answer we listen
  // that long for any answer that should not exist.
  localparam int TAIL_CYCLES    = 2 * SEARCH_LIMIT + 8;
  localparam int HOLD_CYCLES    = 2500;
  localparam int PRESSURE_ITEMS = 8;
  localparam int RANDOM_ITEMS   = 75;
  localparam int MAX_REPORTS    = 10;

  // Stall patterns of the answer side.
  localparam int STALL_NONE   = 0;
  localparam int STALL_HALF   = 1;
  localparam int STALL_SPARSE = 2;

  // One expected answer, tagged with the query that caused it for reporting.
  typedef struct {
    logic [TARGET_W-1:0] target;
    logic                found;
    logic [BASE_W-1:0]   base;
  } answer_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [TARGET_W-1:0] in_target_count;
  logic                out_valid;
  logic                out_ready;
  logic                out_found;
  logic [BASE_W-1:0]   out_factorial_base;

  // least_factor[m] is the smallest prime dividing m, or 0 when m is prime or below 2.
  // factor_total[x] is the number of prime factors of x!, with multiplicity.
  int least_factor [0:SEARCH_LIMIT];
  int omega_count  [0:SEARCH_LIMIT];
  int factor_total [0:SEARCH_LIMIT];

  answer_t expected_answers[$];
  int      mismatch_count;
  int      cycle_count;
  int      burst_left;
  // The test sequence flips hold_toggle to ask the answer side for a long
  // hold-off; the receiver counts the hold itself.
  logic    hold_toggle;

  factorial_prime_count_inverse_unit #(
    .SEARCH_LIMIT(SEARCH_LIMIT),
    .COUNT_LIMIT (COUNT_LIMIT)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_target_count   (in_target_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_factorial_base(out_factorial_base)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Builds the running totals with a smallest-factor sieve: the factor count
  // of m is one more than that of m divided by its smallest prime.
  function automatic void build_factor_totals();
    int p;
    int m;
    for (m = 0; m <= SEARCH_LIMIT; m++) begin
      least_factor[m] = 0;
    end
    for (p = 2; p * p <= SEARCH_LIMIT; p++) begin
      if (least_factor[p] == 0) begin
        for (m = p * p; m <= SEARCH_LIMIT; m += p) begin
          if (least_factor[m] == 0) begin
            least_factor[m] = p;
          end
        end
      end
    end
    omega_count[0]  = 0;
    omega_count[1]  = 0;
    factor_total[0] = 0;
    factor_total[1] = 0;
    for (m = 2; m <= SEARCH_LIMIT; m++) begin
      if (least_factor[m] == 0) begin
        omega_count[m] = 1;
      end else begin
        omega_count[m] = omega_count[m / least_factor[m]] + 1;
      end
      factor_total[m] = factor_total[m - 1] + omega_count[m];
    end
  endfunction

  // The totals grow strictly from x = 2 on, so a binary search finds the
  // single x that matches, if any. A zero target answers x = 0, since 0! = 1
  // has no prime factors. Targets above the count limit are never searched.
  function automatic answer_t predict_answer(input logic [TARGET_W-1:0] target);
    answer_t ans;
    int      want;
    int      lo;
    int      hi;
    int      mid;
    ans.target = target;
    ans.found  = 1'b0;
    ans.base   = '0;
    want       = int'(target);
    if (want == 0) begin
      ans.found = 1'b1;
    end else if (want <= COUNT_LIMIT) begin
      lo = 2;
      hi = SEARCH_LIMIT;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (factor_total[mid] == want) begin
          ans.found = 1'b1;
          ans.base  = mid[BASE_W-1:0];
          lo        = hi + 1;
        end else if (factor_total[mid] < want) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return ans;
  endfunction

  // Random targets stay in the low range so that each walk is short. Close
  // to half of them are exact totals, so many queries end in a match; the
  // rest land anywhere and often fall between two totals.
  function automatic logic [TARGET_W-1:0] random_target();
    int pick;
    int x;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      return '0;
    end else if (pick < 48) begin
      x = $urandom_range(2, 700);
      return TARGET_W'(factor_total[x]);
    end else if (pick < 93) begin
      return TARGET_W'($urandom_range(1, 2000));
    end else begin
      x = $urandom_range(700, 5000);
      return TARGET_W'(factor_total[x] + $urandom_range(0, 1));
    end
  endfunction

  // Sends one query and waits for its transaction. Called at a rising edge.
  // The sender works in bursts; at the end of a burst valid drops for a
  // random gap before the next query is offered.
  // Valid stays high after the transaction so that a following query in the
  // same burst goes out with no bubble.
  task automatic send_query(input logic [TARGET_W-1:0] target);
    answer_t ans;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    ans = predict_answer(target);
    in_valid        <= 1'b1;
    in_target_count <= target;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_answers = {expected_answers, ans};
  endtask

  // Stops offering queries and waits until every outstanding answer is in.
  // It always waits for a rising edge before it returns, so valid is never
  // lowered and raised in the same time step.
  task automatic wait_for_answers();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_answers.size() != 0);
  endtask

  // Short walks around the start of the table: the zero target, the first
  // totals 1, 2 and 4, the skipped total 3, and a run of neighbors that mixes
  // matches with misses. Two zero targets back to back use the short path
  // twice in a row.
  task automatic test_directed_edges();
    int t;
    for (t = 0; t <= 12; t++) begin
      send_query(TARGET_W'(t));
    end
    burst_left = 2;
    send_query('0);
    send_query('0);
    wait_for_answers();
  endtask

  // The two longest walks: the total of the last table entry, which matches
  // at x = SEARCH_LIMIT, and the largest target the field holds, which runs
  // off the end of the table and is reported as not possible. The latter
  // also sets every bit of the target field.
  task automatic test_search_limit();
    send_query(TARGET_W'(factor_total[SEARCH_LIMIT]));
    send_query({TARGET_W{1'b1}});
    wait_for_answers();
  endtask

  // The answer side holds off for a long stretch while the query side keeps
  // offering short queries back to back. The block takes one query while its
  // previous answer waits, then stalls in_ready until the hold ends.
  task automatic test_output_backpressure();
    int n;
    hold_toggle = ~hold_toggle;
    burst_left  = PRESSURE_ITEMS;
    for (n = 0; n < PRESSURE_ITEMS; n++) begin
      send_query(TARGET_W'($urandom_range(1, 60)));
    end
    wait_for_answers();
  endtask

  // Random queries in bursts, with one full pause halfway through.
  task automatic test_random_queries();
    int n;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        wait_for_answers();
      end
      send_query(random_target());
    end
    wait_for_answers();
  endtask

  // Answer side: checks each transaction against the oldest expectation and
  // then drives out_ready for the next cycle. The values read right after the
  // edge are the ones the block saw at that edge. Stalls follow a mode that is
  // drawn anew at random: always ready, ready half the time, or ready with a
  // chance of one in five. A hold request overrides the mode.
  initial begin
    answer_t ans;
    int      hold_left;
    int      mode_left;
    int      stall_mode;
    logic    hold_seen;
    logic    take;
    hold_left  = 0;
    mode_left  = 0;
    stall_mode = STALL_NONE;
    hold_seen  = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (expected_answers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] unexpected answer: found=%0d base=%0d", $realtime,
                     out_found, out_factorial_base);
          end
        end else begin
          ans = expected_answers.pop_front();
          if (out_found !== ans.found || out_factorial_base !== ans.base) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("[%0t] target %0d: expected found=%0d base=%0d, got found=%0d base=%0d",
                       $realtime, ans.target, ans.found, ans.base, out_found,
                       out_factorial_base);
            end
          end
        end
      end
      if (hold_toggle !== hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(STALL_NONE, STALL_SPARSE);
        mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        case (stall_mode)
          STALL_NONE: take = 1'b1;
          STALL_HALF: take = 1'($urandom_range(0, 1));
          default:    take = ($urandom_range(0, 4) == 0);
        endcase
      end
      out_ready <= take;
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** factorial_prime_count_inverse_unit: FAILED **");
    $finish;
  end

  // Main sequence. The block clears and fills its count table after reset
  // with in_ready low; the first query simply waits for it.
  initial begin
    mismatch_count  = 0;
    burst_left      = 0;
    hold_toggle     = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_target_count = '0;
    build_factor_totals();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_search_limit();
    test_output_backpressure();
    test_random_queries();

    // Listen for stray answers after the last expected one.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("** factorial_prime_count_inverse_unit: PASSED **");
    end else begin
      $display("** factorial_prime_count_inverse_unit: FAILED **");
    end
    $finish;
  end

endmodule
